/* sv/tli_pkg.sv */
// Shared codes for the breakpoint-table interpolator.
// No dependencies; imported by table_linear_interp_bsearch_top.
`default_nettype none

package tli_pkg;

    // s_tuser: item kind
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // m_tuser: where the query fell
    typedef logic [1:0] range_flag_t;
    localparam range_flag_t FLAG_INSIDE = 2'd0;
    localparam range_flag_t FLAG_BELOW  = 2'd1;
    localparam range_flag_t FLAG_ABOVE  = 2'd2;

    localparam int IDX_W = 8;   // entry_index / bracket_idx width
    localparam int LEN_W = 9;   // table_len register width

endpackage

`default_nettype wire

/* sv/table_linear_interp_bsearch_top.sv */
// Queries clamped below resolve after the first-entry check, those clamped above after the last-entry check;
// inside the table the binary search runs, then the interpolation multiply and a bit-serial divide.
// Throughput: one query at a time, set by the binary-search table reads and the bit-serial
// divider (one quotient bit per cycle).
// aresetn (synchronous) clears the sequencer, output valid and table_len (to 2);
// table contents are undefined until written.
// Breakpoint table with binary search and exact linear interpolation.
// Depends on tli_pkg.
`default_nettype none

module table_linear_interp_bsearch_top
    import tli_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration: table_len
    input  wire logic                 cfg_we,
    input  wire logic [LEN_W-1:0]     cfg_wdata,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // entry_index, entry_x, entry_y, query_x (zero padded)
    input  wire logic [((IDX_W + 3 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // mode
    input  wire logic                 s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // result_y, bracket_idx (zero padded)
    output logic [((DATA_WIDTH + IDX_W + 7) / 8) * 8 - 1:0] m_tdata,
    // range_flag
    output logic [1:0]                m_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int OUT_W = ((DATA_WIDTH + IDX_W + 7) / 8) * 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int MW    = DW + 1;              // operand magnitude width
    localparam int PW    = 2 * MW;              // product / dividend width
    localparam int H     = (MW + 1) / 2;        // multiplier half width
    localparam int SW    = DW + 3;              // final sum width
    localparam int CW    = $clog2(MW + 1);

    localparam int EX_LO = IDX_W;
    localparam int EY_LO = IDX_W + DW;
    localparam int QX_LO = IDX_W + 2 * DW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LD_FIRST, ST_CHK_FIRST, ST_CHK_LAST, ST_SEARCH, ST_CMP,
        ST_LD_LO, ST_LD_HI, ST_DIFF, ST_MUL_LO, ST_MUL_HI, ST_DIV_CHK, ST_DIV,
        ST_SUM, ST_OUT
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0]     table_len_reg;

    logic [DW-1:0]        x_mem [DEPTH];
    logic [DW-1:0]        y_mem [DEPTH];
    logic signed [DW-1:0] x_rd_reg, y_rd_reg;
    logic [AW-1:0]        rd_addr;

    logic signed [DW-1:0] q_reg, xl_reg, yl_reg;
    logic [AW-1:0]        first_reg, last_reg;
    logic [MW-1:0]        mag_a_reg, mag_b_reg, mag_d_reg;
    logic                 neg_reg, big_reg;
    logic [PW-1:0]        div_reg;
    logic [CW-1:0]        cnt_reg;

    logic signed [DW-1:0] res_reg;
    range_flag_t          flag_reg;
    logic [AW-1:0]        idx_reg;

    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;
    logic [1:0]           m_tuser_reg;
    logic                 out_load;

    // input fields
    logic [IDX_W-1:0]     in_index;
    logic [DW-1:0]        in_x, in_y, in_q;
    logic                 in_beat, wr_en;

    assign in_index = s_tdata[IDX_W-1:0];
    assign in_x     = s_tdata[EX_LO +: DW];
    assign in_y     = s_tdata[EY_LO +: DW];
    assign in_q     = s_tdata[QX_LO +: DW];
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign wr_en    = in_beat && (s_tuser == MODE_WRITE) && (32'(in_index) < DEPTH);

    // entries in use, clamped to 2..DEPTH
    logic [LW-1:0] len_eff;
    always_comb begin
        priority if (table_len_reg < LEN_W'(2)) begin
            len_eff = LW'(2);
        end else if (32'(table_len_reg) > DEPTH) begin
            len_eff = LW'(DEPTH);
        end else begin
            len_eff = LW'(table_len_reg);
        end
    end

    // search bracket arithmetic
    logic [AW:0]   first_w, last_w, mid_w;
    logic [AW-1:0] mid;
    assign first_w = {1'b0, first_reg};
    assign last_w  = {1'b0, last_reg};
    assign mid_w   = (first_w + last_w) >> 1;
    assign mid     = mid_w[AW-1:0];

    logic [AW-1:0] new_first, new_last;
    always_comb begin
        new_first = first_reg;
        new_last  = last_reg;
        if (q_reg < x_rd_reg) begin
            new_last = mid;
        end else begin
            new_first = mid;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_CHK_FIRST: rd_addr = last_reg;
            ST_SEARCH:    rd_addr = mid;
            ST_LD_LO:     rd_addr = first_reg;
            ST_LD_HI:     rd_addr = first_reg + AW'(1);
            default:      rd_addr = '0;
        endcase
    end

    // table storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[AW'(in_index)] <= in_x;
            y_mem[AW'(in_index)] <= in_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // bracket differences, sign-extended to MW bits
    logic signed [MW-1:0] diff_a, diff_b, diff_d;
    assign diff_a = MW'(q_reg)    - MW'(xl_reg);
    assign diff_b = MW'(y_rd_reg) - MW'(yl_reg);
    assign diff_d = MW'(x_rd_reg) - MW'(xl_reg);

    // shared multiplier, one half of the second operand per cycle
    logic [H-1:0]      mul_b;
    logic [MW+H-1:0]   mul_p;
    assign mul_b = (state_reg == ST_MUL_LO) ? mag_b_reg[H-1:0] : H'(mag_b_reg[MW-1:H]);
    assign mul_p = (MW+H)'(mag_a_reg) * (MW+H)'(mul_b);

    // restoring divide step
    logic [MW:0]   div_sh, div_sub;
    logic          div_ge;
    logic [MW-1:0] div_rem;
    assign div_sh  = {div_reg[PW-1:MW], div_reg[MW-1]};
    assign div_ge  = div_sh >= {1'b0, mag_d_reg};
    assign div_sub = div_sh - {1'b0, mag_d_reg};
    assign div_rem = div_ge ? div_sub[MW-1:0] : div_sh[MW-1:0];

    // quotient at least 2^MW always saturates, so it is capped there
    logic                 div_big;
    assign div_big = div_reg >= {mag_d_reg, {MW{1'b0}}};

    localparam logic signed [SW-1:0] SAT_HI = {4'b0000, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {4'b1111, {(DW-1){1'b0}}};
    logic signed [SW-1:0] quo_mag, quo_s, sum;
    assign quo_mag = big_reg ? {2'b01, {MW{1'b0}}} : SW'(div_reg[MW-1:0]);
    assign quo_s   = neg_reg ? -quo_mag : quo_mag;
    assign sum     = SW'(yl_reg) + quo_s;

    // result moves into the output register once it is free
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            table_len_reg <= LEN_W'(2);
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                table_len_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat && (s_tuser == MODE_QUERY)) begin
                        q_reg     <= in_q;
                        last_reg  <= AW'(len_eff - LW'(1));
                        state_reg <= ST_LD_FIRST;
                    end
                end
                ST_LD_FIRST: begin
                    state_reg <= ST_CHK_FIRST;
                end
                ST_CHK_FIRST: begin
                    if (q_reg <= x_rd_reg) begin
                        res_reg   <= y_rd_reg;
                        flag_reg  <= FLAG_BELOW;
                        idx_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_CHK_LAST;
                    end
                end
                ST_CHK_LAST: begin
                    first_reg <= '0;
                    if (q_reg >= x_rd_reg) begin
                        res_reg   <= y_rd_reg;
                        flag_reg  <= FLAG_ABOVE;
                        idx_reg   <= last_reg;
                        state_reg <= ST_OUT;
                    end else if (last_w > (AW+1)'(1)) begin
                        state_reg <= ST_SEARCH;
                    end else begin
                        state_reg <= ST_LD_LO;
                    end
                end
                ST_SEARCH: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    first_reg <= new_first;
                    last_reg  <= new_last;
                    if (({1'b0, new_first} + (AW+1)'(1)) < {1'b0, new_last}) begin
                        state_reg <= ST_SEARCH;
                    end else begin
                        state_reg <= ST_LD_LO;
                    end
                end
                ST_LD_LO: begin
                    state_reg <= ST_LD_HI;
                end
                ST_LD_HI: begin
                    xl_reg    <= x_rd_reg;
                    yl_reg    <= y_rd_reg;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    flag_reg <= FLAG_INSIDE;
                    idx_reg  <= first_reg;
                    if (diff_d == '0) begin
                        res_reg   <= yl_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        mag_a_reg <= diff_a[MW-1] ? MW'(-diff_a) : MW'(diff_a);
                        mag_b_reg <= diff_b[MW-1] ? MW'(-diff_b) : MW'(diff_b);
                        mag_d_reg <= diff_d[MW-1] ? MW'(-diff_d) : MW'(diff_d);
                        neg_reg   <= diff_a[MW-1] ^ diff_b[MW-1] ^ diff_d[MW-1];
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO: begin
                    div_reg   <= PW'(mul_p);
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    div_reg   <= div_reg + (PW'(mul_p) << H);
                    state_reg <= ST_DIV_CHK;
                end
                ST_DIV_CHK: begin
                    big_reg <= div_big;
                    cnt_reg <= CW'(MW);
                    if (div_big) begin
                        state_reg <= ST_SUM;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    div_reg <= {div_rem, div_reg[MW-2:0], div_ge};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    priority if (sum > SAT_HI) begin
                        res_reg <= SAT_HI[DW-1:0];
                    end else if (sum < SAT_LO) begin
                        res_reg <= SAT_LO[DW-1:0];
                    end else begin
                        res_reg <= sum[DW-1:0];
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        m_tdata_reg  <= OUT_W'({IDX_W'(idx_reg), res_reg});
                        m_tuser_reg  <= flag_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a query keeps the input side closed on the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_tuser == MODE_QUERY) |=> !s_tready)
        else $error("input accepted during a query");

    // search compares only inside a proper bracket
    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (first_reg < last_reg))
        else $error("search bracket collapsed");

    // clamped below always reports the first entry
    a_below_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == FLAG_BELOW) |-> (m_tdata[DW +: IDX_W] == '0))
        else $error("below-range result with nonzero index");

    // range_flag never takes the unused code
    a_flag_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == FLAG_INSIDE || m_tuser == FLAG_BELOW ||
                      m_tuser == FLAG_ABOVE))
        else $error("bad range flag");

endmodule

`default_nettype wire
